[hdl/kcc_pkg.sv]
// Shared types, constants and the key encoder for the two-key code checker.
// Used by the front, queue, back, top level and checker; depends on nothing.
package kcc_pkg;

    localparam int KCC_SCAN_W       = 16;
    localparam int KCC_CHAR_W       = 7;
    localparam int KCC_CFG_IDX_W    = 2;
    localparam int KCC_QUEUE_DEPTH  = 2;

    typedef logic [KCC_SCAN_W-1:0] kcc_scan_t;
    typedef logic [KCC_CHAR_W-1:0] kcc_char_t;
    typedef logic [KCC_CFG_IDX_W-1:0] kcc_cfg_idx_t;

    // Configuration register indexes.
    localparam kcc_cfg_idx_t KCC_CFG_FIRST_KEY  = 2'd0;
    localparam kcc_cfg_idx_t KCC_CFG_SECOND_KEY = 2'd1;

    localparam kcc_char_t KCC_NO_KEY_CHAR     = 7'h5A;
    localparam kcc_char_t KCC_FIRST_KEY_RST   = 7'h41;
    localparam kcc_char_t KCC_SECOND_KEY_RST  = 7'h31;

    // Keypad legend, bit 0 first: * 0 # D 7 8 9 C 4 5 6 B 1 2 3 A.
    localparam kcc_char_t KCC_KEY_TABLE [KCC_SCAN_W] = '{
        7'h2A, 7'h30, 7'h23, 7'h44, 7'h37, 7'h38, 7'h39, 7'h43,
        7'h34, 7'h35, 7'h36, 7'h42, 7'h31, 7'h32, 7'h33, 7'h41
    };

    // One key event handed from the front to the back.
    typedef struct packed {
        kcc_scan_t edge_mask;
        logic      second;
    } kcc_entry_t;

    // Lowest set bit of the mask, as its legend character.
    function automatic kcc_char_t kcc_encode_lowest(input kcc_scan_t mask);
        kcc_char_t ch;
        ch = KCC_NO_KEY_CHAR;
        for (int i = KCC_SCAN_W - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                ch = KCC_KEY_TABLE[i];
            end
        end
        return ch;
    endfunction

endpackage

[hdl/kcc_front.sv]
// Front end: pairs scans, debounces, finds rising edges and runs the key sequencer.
// Pushes one key event per accepted key into the queue; depends on kcc_pkg.
module kcc_front
    import kcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  kcc_scan_t  key_matrix,
    input  logic       queue_full,
    output logic       push,
    output kcc_entry_t push_entry
);

    typedef enum logic [1:0] {
        PH_DISCARD_FIRST,
        PH_WAIT_FIRST,
        PH_DISCARD_SECOND,
        PH_WAIT_SECOND
    } phase_t;

    phase_t    phase_reg, phase_next;
    logic      half_reg;
    kcc_scan_t first_scan_reg;
    kcc_scan_t prev_reg;
    kcc_scan_t sample;
    kcc_scan_t edge_mask;
    logic      accept;
    logic      pair_done;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign pair_done = accept && half_reg;
    assign sample    = first_scan_reg & key_matrix;
    assign edge_mask = sample & ~prev_reg;

    always_comb
    begin
        phase_next = phase_reg;
        push       = 1'b0;
        unique case (phase_reg)
            PH_DISCARD_FIRST:  phase_next = PH_WAIT_FIRST;
            PH_WAIT_FIRST:
            begin
                if (edge_mask != '0)
                begin
                    phase_next = PH_DISCARD_SECOND;
                    push       = pair_done;
                end
            end
            PH_DISCARD_SECOND: phase_next = PH_WAIT_SECOND;
            PH_WAIT_SECOND:
            begin
                if (edge_mask != '0)
                begin
                    phase_next = PH_DISCARD_FIRST;
                    push       = pair_done;
                end
            end
            default:           phase_next = PH_DISCARD_FIRST;
        endcase
    end

    assign push_entry.edge_mask = edge_mask;
    assign push_entry.second    = (phase_reg == PH_WAIT_SECOND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DISCARD_FIRST;
            half_reg       <= 1'b0;
            first_scan_reg <= '0;
            prev_reg       <= '0;
        end
        else if (accept)
        begin
            half_reg <= !half_reg;
            if (!half_reg)
            begin
                first_scan_reg <= key_matrix;
            end
            else
            begin
                prev_reg  <= sample;
                phase_reg <= phase_next;
            end
        end
    end

endmodule

[hdl/kcc_queue.sv]
// Short FIFO of key events between the front and the back.
// Depth is a parameter, two by default; depends on kcc_pkg.
module kcc_queue
    import kcc_pkg::*;
#(
    parameter int DEPTH = KCC_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  kcc_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output kcc_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kcc_entry_t         slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/kcc_back.sv]
// Back end: encodes key events, checks the code and holds the result register.
// Owns the code registers; depends on kcc_pkg.
module kcc_back
    import kcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  kcc_cfg_idx_t cfg_index,
    input  kcc_char_t    cfg_data,
    input  logic         queue_not_empty,
    input  kcc_entry_t   head,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output kcc_char_t    key_char,
    output logic         key_position,
    output logic         code_match
);

    kcc_char_t code_first_reg;
    kcc_char_t code_second_reg;
    kcc_char_t held_first_reg;
    logic      out_valid_reg;
    kcc_char_t key_char_reg;
    logic      key_position_reg;
    logic      code_match_reg;
    kcc_char_t head_char;

    assign head_char = kcc_encode_lowest(head.edge_mask);
    assign pop       = queue_not_empty && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_first_reg  <= KCC_FIRST_KEY_RST;
            code_second_reg <= KCC_SECOND_KEY_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                KCC_CFG_FIRST_KEY:  code_first_reg  <= cfg_data;
                KCC_CFG_SECOND_KEY: code_second_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            held_first_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                if (!head.second)
                begin
                    held_first_reg <= head_char;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            key_char_reg     <= head_char;
            key_position_reg <= head.second;
            code_match_reg   <= head.second && (held_first_reg == code_first_reg)
                                && (head_char == code_second_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign key_char     = key_char_reg;
    assign key_position = key_position_reg;
    assign code_match   = code_match_reg;

endmodule

[hdl/keypad_two_key_code_check_core.sv]
// Top level of the two-key keypad code checker: front, key event queue, back.
// Depends on kcc_pkg, kcc_front, kcc_queue and kcc_back.
//
// Usage: each transfer on the input channel (in_valid/in_ready, key_matrix) is one
// full scan of the 16-key matrix. Scans are taken in pairs and ANDed; rising edges
// of that debounced sample drive a sequencer that skips one sample, waits for the
// first key, skips one sample and waits for the second key. Each accepted key is
// one transfer on the output channel (out_valid/out_ready) with key_char,
// key_position (0 first, 1 second) and, on the second key, code_match.
// Throughput is one scan per cycle while the queue is not full; the front's
// registers change only on an accepted scan. A key result passes through the event
// queue and then the output register before it shows on out_valid. When the
// receiver stalls, the output register holds its result, the queue (QUEUE_DEPTH
// events) fills behind it and only then does in_ready drop. The user must write
// the code registers through cfg_write/cfg_index/cfg_data only while idle; the
// block does not enforce it. Reset clears the pairing, the debounce history and
// the sequencer, empties the queue and restores the code to 'A' then '1'.
module keypad_two_key_code_check_core
    import kcc_pkg::*;
#(
    parameter int QUEUE_DEPTH = KCC_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  kcc_cfg_idx_t cfg_index,
    input  kcc_char_t    cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  kcc_scan_t    key_matrix,
    output logic         out_valid,
    input  logic         out_ready,
    output kcc_char_t    key_char,
    output logic         key_position,
    output logic         code_match
);

    logic       push;
    kcc_entry_t push_entry;
    logic       queue_full;
    logic       pop;
    logic       queue_not_empty;
    kcc_entry_t head;

    kcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key_matrix (key_matrix),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    kcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .head       (head)
    );

    kcc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .queue_not_empty (queue_not_empty),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .key_char        (key_char),
        .key_position    (key_position),
        .code_match      (code_match)
    );

endmodule

[hdl/kcc_checker.sv]
// Port-level checks for keypad_two_key_code_check_core, attached by bind.
// Depends on kcc_pkg.
module kcc_checker
    import kcc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input kcc_char_t key_char,
    input logic      key_position,
    input logic      code_match
);

    // A result that waits for the receiver keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_char)
        && $stable(key_position) && $stable(code_match))
        else $error("stalled result changed");

    // Only a second key can report a code match.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !key_position |-> !code_match)
        else $error("code match on a first key");

    // A key is only reported on a nonzero edge mask, so never as the no-key code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_char != KCC_NO_KEY_CHAR)
        else $error("result carries the no-key character");

    // Reset leaves no result pending.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    // A scan accepted while a result waits for a stalled receiver does not make the
    // pending result drop: out_valid stays high.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && in_valid && in_ready |=> out_valid)
        else $error("pending result lost while input was taken");

endmodule

bind keypad_two_key_code_check_core kcc_checker u_kcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_char     (key_char),
    .key_position (key_position),
    .code_match   (code_match)
);
